### rtl/fixed_point_alu_assert.svh
// assertion macros shared by the alu checker
// no dependencies; include with the bare file name
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define FXALU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fxalu assertion failed");

// next-cycle implication, disabled while reset is active
`define FXALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fxalu assertion failed");

`endif

### rtl/fxalu_pkg.sv
// types and constants for the 16.16 fixed-point alu
// no dependencies
package fxalu_pkg;

    localparam int WORD_W = 32;
    localparam int SHAMT_W = 5;

    localparam logic [WORD_W-1:0] FIX_ONE = 32'h0001_0000;
    localparam logic [WORD_W-1:0] FIX_MINUS_ONE = 32'hffff_0000;
    localparam logic [WORD_W-1:0] FRAC_MASK = 32'h0000_ffff;
    localparam logic [SHAMT_W-1:0] MAX_SHIFT = 5'd31;

    typedef enum logic [3:0] {
        OP_MAX  = 4'd0,
        OP_MIN  = 4'd1,
        OP_MID  = 4'd2,
        OP_CEIL = 4'd3,
        OP_FLR  = 4'd4,
        OP_ABS  = 4'd5,
        OP_SGN  = 4'd6,
        OP_AND  = 4'd7,
        OP_OR   = 4'd8,
        OP_XOR  = 4'd9,
        OP_NOT  = 4'd10,
        OP_SHL  = 4'd11,
        OP_SHR  = 4'd12,
        OP_LSHR = 4'd13,
        OP_ROTL = 4'd14,
        OP_ROTR = 4'd15
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [WORD_W-1:0]  a;
        logic [WORD_W-1:0]  b;
        logic [WORD_W-1:0]  c;
        logic               gt_ab;
        logic               gt_bc;
        logic               gt_ac;
        logic [SHAMT_W-1:0] shamt;
        logic               sh_big;
        logic [SHAMT_W-1:0] rot;
    } s1_t;

    typedef struct packed {
        logic              sel_arith;
        logic [WORD_W-1:0] arith;
        logic [WORD_W-1:0] bitw;
    } s2_t;

endpackage

### rtl/fixed_point_alu.sv
// fixed_point_alu: three-stage pipelined alu over signed 16.16 words
// path: an accepted request is registered in s1_reg, s2_reg and s3_reg in turn, then shows as result
// throughput: one request per cycle; each stage holds while the next is full and itself held
// reset: rst_n asynchronous active low clears all stage valid bits
// depends on fxalu_pkg
module fixed_point_alu (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [3:0]                        mode,
    input  logic signed [fxalu_pkg::WORD_W-1:0] operand_a,
    input  logic signed [fxalu_pkg::WORD_W-1:0] operand_b,
    input  logic signed [fxalu_pkg::WORD_W-1:0] operand_c,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [fxalu_pkg::WORD_W-1:0] result
);
    import fxalu_pkg::*;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    s1_t  s1_reg;
    s1_t  s1_next;
    s2_t  s2_reg;
    s2_t  s2_next;
    logic [WORD_W-1:0] s3_reg;
    logic [WORD_W-1:0] s3_next;

    logic en1;
    logic en2;
    logic en3;

    logic [WORD_W-1:0]  neg_b;
    logic [WORD_W-1:0]  ceil_w;
    logic [WORD_W-1:0]  abs_w;
    logic [2*WORD_W-1:0] dbl;
    logic [2*WORD_W-1:0] rotl_w;
    logic [2*WORD_W-1:0] rotr_w;
    logic [SHAMT_W-1:0] shr_n;

    // stall chain
    assign en3 = !s3_valid_reg || !res_stall;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign req_stall = !en1;

    // stage 1: compares and shift count
    always_comb
    begin
        neg_b = 32'd0 - operand_b;
        s1_next.op = op_t'(mode);
        s1_next.a = operand_a;
        s1_next.b = operand_b;
        s1_next.c = operand_c;
        s1_next.gt_ab = operand_a > operand_b;
        s1_next.gt_bc = operand_b > operand_c;
        s1_next.gt_ac = operand_a > operand_c;
        s1_next.sh_big = !operand_b[WORD_W-1] && (operand_b[30:21] != 10'd0);
        s1_next.shamt = operand_b[WORD_W-1] ? '0 : operand_b[20:16];
        s1_next.rot = operand_b[WORD_W-1] ? (5'd0 - neg_b[20:16]) : operand_b[20:16];
    end

    // stage 2: per-group results
    always_comb
    begin
        ceil_w = (s1_reg.a + FRAC_MASK) & ~FRAC_MASK;
        abs_w = s1_reg.a[WORD_W-1] ? (32'd0 - s1_reg.a) : s1_reg.a;
        dbl = {s1_reg.a, s1_reg.a};
        rotl_w = dbl << s1_reg.rot;
        rotr_w = dbl >> s1_reg.rot;
        shr_n = s1_reg.sh_big ? MAX_SHIFT : s1_reg.shamt;
        s2_next.sel_arith = 1'b0;
        s2_next.arith = s1_reg.a;
        s2_next.bitw = s1_reg.a;
        unique case (s1_reg.op)
            OP_MAX:
            begin
                s2_next.sel_arith = 1'b1;
                s2_next.arith = s1_reg.gt_ab ? s1_reg.a : s1_reg.b;
            end
            OP_MIN:
            begin
                s2_next.sel_arith = 1'b1;
                s2_next.arith = s1_reg.gt_ab ? s1_reg.b : s1_reg.a;
            end
            OP_MID:
            begin
                s2_next.sel_arith = 1'b1;
                if (s1_reg.gt_ab)
                    s2_next.arith = s1_reg.gt_bc ? s1_reg.b
                                  : (s1_reg.gt_ac ? s1_reg.c : s1_reg.a);
                else
                    s2_next.arith = s1_reg.gt_ac ? s1_reg.a
                                  : (s1_reg.gt_bc ? s1_reg.c : s1_reg.b);
            end
            OP_CEIL:
            begin
                s2_next.sel_arith = 1'b1;
                s2_next.arith = ceil_w;
            end
            OP_FLR:
            begin
                s2_next.sel_arith = 1'b1;
                s2_next.arith = s1_reg.a & ~FRAC_MASK;
            end
            OP_ABS:
            begin
                s2_next.sel_arith = 1'b1;
                s2_next.arith = abs_w;
            end
            OP_SGN:
            begin
                s2_next.sel_arith = 1'b1;
                s2_next.arith = s1_reg.a[WORD_W-1] ? FIX_MINUS_ONE : FIX_ONE;
            end
            OP_AND:  s2_next.bitw = s1_reg.a & s1_reg.b;
            OP_OR:   s2_next.bitw = s1_reg.a | s1_reg.b;
            OP_XOR:  s2_next.bitw = s1_reg.a ^ s1_reg.b;
            OP_NOT:  s2_next.bitw = ~s1_reg.a;
            OP_SHL:  s2_next.bitw = s1_reg.sh_big ? '0 : (s1_reg.a << s1_reg.shamt);
            OP_SHR:  s2_next.bitw = $signed(s1_reg.a) >>> shr_n;
            OP_LSHR: s2_next.bitw = s1_reg.sh_big ? '0 : (s1_reg.a >> s1_reg.shamt);
            OP_ROTL: s2_next.bitw = rotl_w[2*WORD_W-1:WORD_W];
            OP_ROTR: s2_next.bitw = rotr_w[WORD_W-1:0];
            default: s2_next.bitw = s1_reg.a;
        endcase
    end

    // stage 3: final select into the output register
    assign s3_next = s2_reg.sel_arith ? s2_reg.arith : s2_reg.bitw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= req_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
        if (en3)
            s3_reg <= s3_next;
    end

    assign res_valid = s3_valid_reg;
    assign result = s3_reg;

endmodule

### rtl/fxalu_checker.sv
// port-level checker for fixed_point_alu, bound into every fixed_point_alu instance
// depends on fixed_point_alu_assert.svh
`include "fixed_point_alu_assert.svh"

module fxalu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic [31:0] result
);

    // an empty output register means the pipeline flows
    `FXALU_ASSERT_IMPLY(a_no_stall_when_empty, clk, rst_n, !res_valid, !req_stall)

    // an accepted request moves through the stage registers to res_valid while res_stall stays low
    `FXALU_ASSERT_NEXT(a_latency, clk, rst_n, (req_valid && !req_stall) ##1 !res_stall ##1 !res_stall, res_valid)

    // a stalled result stays
    `FXALU_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(result))

endmodule

bind fixed_point_alu fxalu_checker u_fxalu_checker (.*);

### tb/testbench.sv
// self-checking testbench for fixed_point_alu: directed and random requests
// checked against a behavioral predictor of the 16.16 fixed-point alu
// depends on fxalu_pkg and the fixed_point_alu rtl
`timescale 1ns / 1ps

module testbench;
    import fxalu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQUESTS = 1250;
    localparam int QUIET_TAIL = 150;
    localparam int DRAIN_CYCLES = 12;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_stall;
    logic [3:0]                mode;
    logic signed [WORD_W-1:0]  operand_a;
    logic signed [WORD_W-1:0]  operand_b;
    logic signed [WORD_W-1:0]  operand_c;
    logic                      res_valid;
    logic                      res_stall;
    logic signed [WORD_W-1:0]  result;

    logic [WORD_W-1:0] expected_results[$];
    int                fail_count = 0;
    bit                gaps_on = 1'b0;

    fixed_point_alu i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .mode      (mode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .operand_c (operand_c),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [WORD_W-1:0] alu_predict(op_t op, logic signed [WORD_W-1:0] a,
                                                      logic signed [WORD_W-1:0] b,
                                                      logic signed [WORD_W-1:0] c);
        logic [WORD_W-1:0]   ua;
        logic [WORD_W-1:0]   ub;
        logic [WORD_W-1:0]   count;
        logic [WORD_W-1:0]   shift;
        logic [4:0]          amount;
        logic [4:0]          rot;
        logic [2*WORD_W-1:0] twice;
        logic [WORD_W-1:0]   r;
        ua = a;
        ub = b;
        // integer part of b, truncated toward zero
        if (!ub[31])
            count = ub >> 16;
        else
            count = 32'd0 - ((32'd0 - ub) >> 16);
        shift = count[31] ? 32'd0 : count;
        rot = count[4:0];
        twice = {ua, ua};
        amount = shift[4:0];
        case (op)
            OP_MAX:  r = (a > b) ? a : b;
            OP_MIN:  r = (a > b) ? b : a;
            OP_MID:
            begin
                if (a > b)
                    r = (b > c) ? b : ((a > c) ? c : a);
                else
                    r = (a > c) ? a : ((b > c) ? c : b);
            end
            OP_CEIL: r = (ua + FRAC_MASK) & ~FRAC_MASK;
            OP_FLR:  r = ua & ~FRAC_MASK;
            OP_ABS:  r = ua[31] ? 32'd0 - ua : ua;
            OP_SGN:  r = ua[31] ? FIX_MINUS_ONE : FIX_ONE;
            OP_AND:  r = ua & ub;
            OP_OR:   r = ua | ub;
            OP_XOR:  r = ua ^ ub;
            OP_NOT:  r = ~ua;
            OP_SHL:  r = (shift > 32'd31) ? 32'd0 : (ua << amount);
            OP_SHR:
            begin
                if (shift > 32'd31)
                    amount = MAX_SHIFT;
                r = a >>> amount;
            end
            OP_LSHR: r = (shift > 32'd31) ? 32'd0 : (ua >> amount);
            OP_ROTL:
            begin
                twice = twice << rot;
                r = twice[2*WORD_W-1:WORD_W];
            end
            default:
            begin
                twice = twice >> rot;
                r = twice[WORD_W-1:0];
            end
        endcase
        return r;
    endfunction

    task automatic send_request(op_t op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                logic [WORD_W-1:0] c);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            mode <= 4'($urandom);
            operand_a <= $urandom;
            operand_b <= $urandom;
            operand_c <= $urandom;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_valid <= 1'b1;
        mode <= op;
        operand_a <= a;
        operand_b <= b;
        operand_c <= c;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_results.push_back(alu_predict(op, a, b, c));
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: w = 32'h7fff_ffff;
                    1: w = 32'h8000_0000;
                    2: w = 32'h0000_0000;
                    3: w = 32'hffff_ffff;
                    4: w = FIX_ONE;
                    5: w = FIX_MINUS_ONE;
                    default: w = FRAC_MASK;
                endcase
            end
            1: w = {16'($signed($urandom_range(0, 64)) - 16'sd32), 16'($urandom)};
            2: w = {16'($urandom), 16'h0000};
            3: w = {16'($urandom), $urandom_range(0, 1) ? 16'hffff : 16'h0001};
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic test_compare_select();
        send_request(OP_MAX, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_request(OP_MIN, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_request(OP_MAX, 32'hffff_ffff, 32'h0000_0001, 32'h0);
        send_request(OP_MID, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000);
        send_request(OP_MID, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000);
        send_request(OP_MID, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000);
        send_request(OP_MID, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000);
    endtask

    task automatic test_rounding_sign();
        send_request(OP_CEIL, 32'h7fff_0001, $urandom, $urandom);
        send_request(OP_CEIL, 32'hffff_8000, $urandom, $urandom);
        send_request(OP_CEIL, 32'h0001_0000, $urandom, $urandom);
        send_request(OP_FLR, 32'hffff_8000, $urandom, $urandom);
        send_request(OP_ABS, 32'h8000_0000, $urandom, $urandom);
        send_request(OP_SGN, 32'h0000_0000, $urandom, $urandom);
        send_request(OP_SGN, 32'h8000_0000, $urandom, $urandom);
    endtask

    task automatic test_bitwise();
        send_request(OP_AND, 32'hffff_ffff, 32'h5a5a_a5a5, $urandom);
        send_request(OP_OR, 32'h0000_0000, 32'ha5a5_5a5a, $urandom);
        send_request(OP_XOR, 32'hffff_0000, 32'h00ff_ff00, $urandom);
        send_request(OP_NOT, 32'h8000_0001, $urandom, $urandom);
    endtask

    task automatic test_shift_rotate();
        // negative count, large counts, fractional count, zero and wrapped rotates
        send_request(OP_SHL, 32'h0001_0001, 32'hfffe_8000, $urandom);
        send_request(OP_SHL, 32'hffff_ffff, 32'h0020_0000, $urandom);
        send_request(OP_SHR, 32'h8000_0000, 32'h0028_0000, $urandom);
        send_request(OP_LSHR, 32'h8000_0000, 32'h0000_c000, $urandom);
        send_request(OP_LSHR, 32'hffff_ffff, 32'h7fff_ffff, $urandom);
        send_request(OP_ROTL, 32'h8000_0001, 32'h0000_8000, $urandom);
        send_request(OP_ROTL, 32'h8000_0001, 32'hffff_0000, $urandom);
        send_request(OP_ROTR, 32'h8000_0001, 32'h8000_0000, $urandom);
    endtask

    task automatic test_random_mix();
        op_t               op;
        logic [WORD_W-1:0] b;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n >= RANDOM_REQUESTS - QUIET_TAIL)
                gaps_on = 1'b0;
            else if (n % 64 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            op = op_t'($urandom_range(0, 15));
            b = random_word();
            if (op >= OP_SHL && $urandom_range(0, 3) != 0)
                b = {16'($signed($urandom_range(0, 110)) - 16'sd40), 16'($urandom)};
            send_request(op, random_word(), b, random_word());
        end
    endtask

    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result: expected none, actual %h", result);
                fail_count++;
            end
            else if (result !== expected_results[0])
            begin
                $error("result: expected %h, actual %h", expected_results[0], result);
                fail_count++;
                void'(expected_results.pop_front());
            end
            else
                void'(expected_results.pop_front());
        end
    end

    initial
    begin
        int cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("fixed_point_alu regression: fail");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        mode <= '0;
        operand_a <= '0;
        operand_b <= '0;
        operand_c <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gaps_on = 1'b1;
        test_compare_select();
        test_rounding_sign();
        test_bitwise();
        test_shift_rotate();
        test_random_mix();
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("fixed_point_alu regression: pass");
        else
            $display("fixed_point_alu regression: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/fxalu_pkg.sv
rtl/fixed_point_alu.sv
rtl/fxalu_checker.sv
tb/testbench.sv
